>>> rtl/vnorm_pkg.sv
package vnorm_pkg;

    // Number of vector components, one lane each.
    localparam int LANES = 3;

    // Per-item side information that travels beside the lanes.
    typedef struct packed {
        logic             zero;
        logic [LANES-1:0] neg;
    } t_side;

endpackage

>>> rtl/vnorm_lane.sv
module vnorm_lane #(
    parameter int W = 16,
    parameter int F = 15
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [2*W-1:0] i_sq,
    input  logic [2*W-1:0] i_sum,
    output logic [F:0]     o_mag
);
    import vnorm_pkg::*;

    localparam int QW   = 2 * F + 1;
    localparam int RW   = 2 * W + 1;
    localparam int XW   = QW + 1;
    localparam int NDIV = QW;
    localparam int NSQ  = F + 1;

    // Restoring divider, one quotient bit per stage: D = sq * 2^(2F) / sum.
    logic [RW-1:0]  r_rem [NDIV-1];
    logic [2*W-1:0] r_div [NDIV-1];
    logic [QW-1:0]  r_quo [NDIV];

    // Digit-by-digit square root of D, one result bit per stage.
    logic [QW-1:0]  r_x   [NSQ-1];
    logic [XW-1:0]  r_res [NSQ];

    genvar k;
    generate
        for (k = 0; k < NDIV; k++) begin : g_div
            logic [RW-1:0]  w_sh;
            logic [2*W-1:0] w_din;
            logic [QW-1:0]  w_qin;
            logic           w_ge;
            if (k == 0) begin : g_first
                assign w_sh  = {1'b0, i_sq};
                assign w_din = i_sum;
                assign w_qin = '0;
            end else begin : g_next
                assign w_sh  = {r_rem[k-1][RW-2:0], 1'b0};
                assign w_din = r_div[k-1];
                assign w_qin = r_quo[k-1];
            end
            assign w_ge = (w_sh >= {1'b0, w_din});
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_quo[k] <= {w_qin[QW-2:0], w_ge};
                end
            end
            if (k < NDIV - 1) begin : g_keep
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_rem[k] <= w_ge ? (w_sh - {1'b0, w_din}) : w_sh;
                        r_div[k] <= w_din;
                    end
                end
            end
        end

        for (k = 0; k < NSQ; k++) begin : g_sqrt
            localparam int SH = 2 * (F - k);
            localparam logic [XW-1:0] BITV = {{(XW-1){1'b0}}, 1'b1} << SH;
            logic [QW-1:0] w_xin;
            logic [XW-1:0] w_rin;
            logic [XW-1:0] w_tmp;
            logic          w_ge;
            if (k == 0) begin : g_first
                assign w_xin = r_quo[NDIV-1];
                assign w_rin = '0;
            end else begin : g_next
                assign w_xin = r_x[k-1];
                assign w_rin = r_res[k-1];
            end
            assign w_tmp = w_rin + BITV;
            assign w_ge  = ({1'b0, w_xin} >= w_tmp);
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_res[k] <= w_ge ? ((w_rin >> 1) + BITV) : (w_rin >> 1);
                end
            end
            if (k < NSQ - 1) begin : g_keep
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_x[k] <= w_ge ? (w_xin - w_tmp[QW-1:0]) : w_xin;
                    end
                end
            end
        end
    endgenerate

    assign o_mag = r_res[NSQ-1][F:0];

endmodule

>>> rtl/vnorm_merge.sv
module vnorm_merge #(
    parameter int F = 15
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  vnorm_pkg::t_side                      i_side,
    input  logic [vnorm_pkg::LANES-1:0][F:0]      i_mag,
    output logic                                  o_valid,
    output logic [vnorm_pkg::LANES-1:0][F:0]      o_unit,
    output logic                                  o_zero
);
    import vnorm_pkg::*;

    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};
    localparam logic [F:0] MAXP = {1'b0, {F{1'b1}}};
    localparam logic [F:0] LSB = {{F{1'b0}}, 1'b1};

    logic                        r_valid;
    logic [LANES-1:0][F:0]       r_unit;
    logic                        r_zero;
    logic [LANES-1:0][F:0]       n_unit;

    // Sign, saturation of plus one, and the zero-vector override.
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            if (i_side.zero) begin
                n_unit[i] = '0;
            end else if (i_side.neg[i]) begin
                n_unit[i] = (~i_mag[i]) + LSB;
            end else if (i_mag[i] >= ONE) begin
                n_unit[i] = MAXP;
            end else begin
                n_unit[i] = i_mag[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_unit <= n_unit;
            r_zero <= i_side.zero;
        end
    end

    assign o_valid = r_valid;
    assign o_unit  = r_unit;
    assign o_zero  = r_zero;

endmodule

>>> rtl/vector3_normalizer_unit.sv
// Throughput: one vector per clock; each lane is a fully pipelined divider and square root.
// The whole pipeline advances together and holds while the output transaction stalls.
// Reset (i_rst_n, synchronous, active low) clears all valid flags; data registers keep
// their contents and are ignored until refilled.
module vector3_normalizer_unit #(
    parameter int IN_WIDTH      = 16,
    parameter int OUT_FRAC_BITS = 15
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        s_axis_tvalid,
    output logic                                        s_axis_tready,
    // Fields from bit 0 up: vec_x, vec_y, vec_z, then zero padding.
    input  logic [((3*IN_WIDTH+7)/8)*8-1:0]             s_axis_tdata,
    output logic                                        m_axis_tvalid,
    input  logic                                        m_axis_tready,
    // Fields from bit 0 up: unit_x, unit_y, unit_z, then zero padding.
    output logic [((3*(OUT_FRAC_BITS+1)+7)/8)*8-1:0]    m_axis_tdata,
    // Field: zero_length.
    output logic                                        m_axis_tuser
);
    import vnorm_pkg::*;

    localparam int W   = IN_WIDTH;
    localparam int F   = OUT_FRAC_BITS;
    localparam int OW  = F + 1;
    localparam int ODW = ((3 * OW + 7) / 8) * 8;
    localparam int LL  = 3 * F + 2;   // lane depth: divider plus square root
    localparam logic [W-1:0] LSB = {{(W-1){1'b0}}, 1'b1};

    // One enable moves every stage; a stage may load whenever the output
    // register is empty or its transaction completes this cycle.
    logic w_en;
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    // Stage 1: magnitudes and squares.
    logic                        r1_valid;
    logic [LANES-1:0]            r1_neg;
    logic [LANES-1:0][2*W-1:0]   r1_sq;
    logic [LANES-1:0]            w_neg;
    logic [LANES-1:0][2*W-1:0]   w_sq;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            logic [W-1:0] v;
            logic [W-1:0] m;
            v = s_axis_tdata[i*W +: W];
            w_neg[i] = v[W-1];
            m = v[W-1] ? (~v + LSB) : v;
            w_sq[i] = {{W{1'b0}}, m} * {{W{1'b0}}, m};
        end
    end

    // Stage 2: sum of squares and the zero-vector test.
    logic                        r2_valid;
    logic [LANES-1:0][2*W-1:0]   r2_sq;
    logic [2*W-1:0]              r2_sum;
    t_side                       r2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= s_axis_tvalid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_neg       <= w_neg;
            r1_sq        <= w_sq;
            r2_sq        <= r1_sq;
            r2_sum       <= r1_sq[0] + r1_sq[1] + r1_sq[2];
            r2_side.neg  <= r1_neg;
            r2_side.zero <= ((r1_sq[0] | r1_sq[1] | r1_sq[2]) == '0);
        end
    end

    // Lanes: each one forms floor(sqrt(sq * 2^(2F) / sum)) for its component.
    logic [LANES-1:0][F:0] w_mag;

    genvar g;
    generate
        for (g = 0; g < LANES; g++) begin : g_lane
            vnorm_lane #(.W(W), .F(F)) u_lane (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_sq  (r2_sq[g]),
                .i_sum (r2_sum),
                .o_mag (w_mag[g])
            );
        end
    endgenerate

    // Side information and valid flags march beside the lanes.
    logic  r_sv   [LL];
    t_side r_side [LL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LL; i++) begin
                r_sv[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_sv[0] <= r2_valid;
            for (int i = 1; i < LL; i++) begin
                r_sv[i] <= r_sv[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= r2_side;
            for (int i = 1; i < LL; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // Merge stage: applies signs, saturation and the zero flag, and holds
    // the result until its output transaction completes.
    logic [LANES-1:0][F:0] w_unit;

    vnorm_merge #(.F(F)) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_sv[LL-1]),
        .i_side  (r_side[LL-1]),
        .i_mag   (w_mag),
        .o_valid (m_axis_tvalid),
        .o_unit  (w_unit),
        .o_zero  (m_axis_tuser)
    );

    assign m_axis_tdata = ODW'(w_unit);

    // A zero vector must produce all-zero components.
    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (w_unit == '0))
        else $error("zero-length result carries nonzero components");

    // A nonzero vector has a component of at least 1/sqrt(3), never all zeros.
    a_nonzero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (w_unit != '0))
        else $error("nonzero vector normalized to all zeros");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule
